FILE: rtl/core/mbts_pkg.sv
`default_nettype none

package mbts_pkg;

  // Command codes carried in the cmd field of an input item.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SHORT  = 2'd1,
    CMD_BREAK  = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  // Program codes.
  localparam logic [1:0] PROG_NONE  = 2'd0;
  localparam logic [1:0] PROG_SHORT = 2'd1;
  localparam logic [1:0] PROG_BREAK = 2'd2;

  // Motor drive codes.
  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_FWD  = 2'd1;
  localparam logic [1:0] MOTOR_REV  = 2'd2;

  // Phase codes shared by both programs.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_PREP    = 4'd1;
  // Short test phases.
  localparam logic [3:0] PH_S_FWD   = 4'd2;
  localparam logic [3:0] PH_S_STOP  = 4'd3;
  localparam logic [3:0] PH_S_REV   = 4'd4;
  localparam logic [3:0] PH_S_REL   = 4'd5;
  // Breakaway phases.
  localparam logic [3:0] PH_B_FJOLT  = 4'd2;
  localparam logic [3:0] PH_B_FJSTOP = 4'd3;
  localparam logic [3:0] PH_B_FDRV   = 4'd4;
  localparam logic [3:0] PH_B_FDSTOP = 4'd5;
  localparam logic [3:0] PH_B_RJOLT  = 4'd6;
  localparam logic [3:0] PH_B_RJSTOP = 4'd7;
  localparam logic [3:0] PH_B_RDRV   = 4'd8;
  localparam logic [3:0] PH_B_RDSTOP = 4'd9;
  localparam logic [3:0] PH_B_REL    = 4'd10;

  // Configuration register indexes.
  localparam logic [2:0] REG_SHORT_STEP = 3'd0;
  localparam logic [2:0] REG_JOLT       = 3'd1;
  localparam logic [2:0] REG_JOLT_STOP  = 3'd2;
  localparam logic [2:0] REG_DRIVE      = 3'd3;
  localparam logic [2:0] REG_DRIVE_STOP = 3'd4;
  localparam logic [2:0] REG_CYCLES     = 3'd5;
  localparam logic [2:0] REG_MAX_ENERG  = 3'd6;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_SHORT_STEP = 16'd250;
  localparam logic [15:0] RST_JOLT       = 16'd150;
  localparam logic [15:0] RST_JOLT_STOP  = 16'd100;
  localparam logic [15:0] RST_DRIVE      = 16'd1500;
  localparam logic [15:0] RST_DRIVE_STOP = 16'd500;
  localparam logic [3:0]  RST_CYCLES     = 4'd2;
  localparam logic [15:0] RST_MAX_ENERG  = 16'd2000;

  typedef struct packed {
    logic [15:0] short_step_ms;
    logic [15:0] jolt_ms;
    logic [15:0] jolt_stop_ms;
    logic [15:0] drive_ms;
    logic [15:0] drive_stop_ms;
    logic [3:0]  total_cycles;
    logic [15:0] max_energized_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       priority_ready;
    logic       priority_active;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       request_priority;
    logic       release_priority;
    logic       release_now;
    logic       behavior_off;
    logic [1:0] program_res;
    logic [3:0] phase_code;
    logic [3:0] cycle_number;
    logic       safety_trip;
  } out_item_t;

  // Motor command implied by a program and phase.
  function automatic logic [1:0] motor_of(input logic [1:0] prog, input logic [3:0] ph);
    logic [1:0] m;
    m = MOTOR_STOP;
    if (prog == PROG_SHORT) begin
      if (ph == PH_S_FWD) m = MOTOR_FWD;
      else if (ph == PH_S_REV) m = MOTOR_REV;
    end else if (prog == PROG_BREAK) begin
      if (ph == PH_B_FJOLT || ph == PH_B_RDRV) m = MOTOR_REV;
      else if (ph == PH_B_FDRV || ph == PH_B_RJOLT) m = MOTOR_FWD;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mbts_cfg_regs.sv
`default_nettype none

module mbts_cfg_regs
  import mbts_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  output cfg_t                         cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SHORT_STEP: cfg_d.short_step_ms    = cfg_wdata_i;
        REG_JOLT:       cfg_d.jolt_ms          = cfg_wdata_i;
        REG_JOLT_STOP:  cfg_d.jolt_stop_ms     = cfg_wdata_i;
        REG_DRIVE:      cfg_d.drive_ms         = cfg_wdata_i;
        REG_DRIVE_STOP: cfg_d.drive_stop_ms    = cfg_wdata_i;
        REG_CYCLES:     cfg_d.total_cycles     = cfg_wdata_i[3:0];
        REG_MAX_ENERG:  cfg_d.max_energized_ms = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_step_ms    <= RST_SHORT_STEP;
      cfg_q.jolt_ms          <= RST_JOLT;
      cfg_q.jolt_stop_ms     <= RST_JOLT_STOP;
      cfg_q.drive_ms         <= RST_DRIVE;
      cfg_q.drive_stop_ms    <= RST_DRIVE_STOP;
      cfg_q.total_cycles     <= RST_CYCLES;
      cfg_q.max_energized_ms <= RST_MAX_ENERG;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/mbts_seq.sv
`default_nettype none

module mbts_seq
  import mbts_pkg::*;
#(
  parameter int unsigned TimerWidth = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_en_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     res_o
);

  localparam int unsigned CmpWidth = (TimerWidth > 16) ? TimerWidth : 16;

  logic [1:0]            prog_q, prog_d;
  logic [3:0]            phase_q, phase_d;
  logic [TimerWidth-1:0] ptimer_q, ptimer_d;
  logic                  eflag_q, eflag_d;
  logic [TimerWidth-1:0] etimer_q, etimer_d;
  logic [3:0]            cycle_q, cycle_d;

  logic [TimerWidth-1:0] pt_inc, et_inc;
  logic [15:0]           dur;
  logic                  timed, done, trip_hit;
  logic                  enter_en, idle_en;
  logic [3:0]            enter_ph;
  logic                  req, rel, relnow, boff, trip;

  // Saturating millisecond counters.
  assign pt_inc = (ptimer_q == '1) ? ptimer_q : ptimer_q + 1'b1;
  assign et_inc = (!eflag_q || etimer_q == '1) ? etimer_q : etimer_q + 1'b1;

  // Duration of the current timed phase.
  always_comb begin
    dur   = cfg_i.short_step_ms;
    timed = 1'b0;
    if (prog_q == PROG_SHORT) begin
      timed = (phase_q == PH_S_FWD) || (phase_q == PH_S_STOP) || (phase_q == PH_S_REV);
    end else begin
      unique case (phase_q)
        PH_B_FJOLT, PH_B_RJOLT: begin
          dur   = cfg_i.jolt_ms;
          timed = 1'b1;
        end
        PH_B_FJSTOP, PH_B_RJSTOP: begin
          dur   = cfg_i.jolt_stop_ms;
          timed = 1'b1;
        end
        PH_B_FDRV, PH_B_RDRV: begin
          dur   = cfg_i.drive_ms;
          timed = 1'b1;
        end
        PH_B_FDSTOP, PH_B_RDSTOP: begin
          dur   = cfg_i.drive_stop_ms;
          timed = 1'b1;
        end
        default: timed = 1'b0;
      endcase
    end
  end

  // A duration beyond the timer range is never reached, which the zero extension gives.
  assign done     = timed && (CmpWidth'(pt_inc) >= CmpWidth'(dur));
  assign trip_hit = (prog_q == PROG_BREAK) && eflag_q &&
                    (CmpWidth'(et_inc) >= CmpWidth'(cfg_i.max_energized_ms));

  always_comb begin
    prog_d   = prog_q;
    phase_d  = phase_q;
    ptimer_d = ptimer_q;
    eflag_d  = eflag_q;
    etimer_d = etimer_q;
    cycle_d  = cycle_q;
    enter_en = 1'b0;
    enter_ph = phase_q;
    idle_en  = 1'b0;
    req      = 1'b0;
    rel      = 1'b0;
    relnow   = 1'b0;
    boff     = 1'b0;
    trip     = 1'b0;

    unique case (cmd_e'(item_i.cmd))
      CMD_SHORT, CMD_BREAK: begin
        if (prog_q == PROG_NONE) begin
          prog_d   = item_i.cmd;
          cycle_d  = (item_i.cmd == PROG_BREAK) ? 4'd1 : 4'd0;
          enter_en = 1'b1;
          enter_ph = PH_PREP;
          req      = 1'b1;
          boff     = 1'b1;
        end
      end
      CMD_CANCEL: begin
        boff = 1'b1;
        if (prog_q != PROG_NONE) begin
          relnow  = 1'b1;
          idle_en = 1'b1;
        end
      end
      default: begin
        if (prog_q != PROG_NONE) begin
          ptimer_d = pt_inc;
          etimer_d = et_inc;
          if (trip_hit) begin
            relnow  = 1'b1;
            trip    = 1'b1;
            idle_en = 1'b1;
          end else if (prog_q == PROG_SHORT) begin
            if (phase_q == PH_PREP) begin
              enter_en = item_i.priority_ready;
              enter_ph = PH_S_FWD;
            end else if (phase_q == PH_S_REL) begin
              idle_en = !item_i.priority_active;
              boff    = !item_i.priority_active;
            end else if (timed) begin
              enter_en = done;
              enter_ph = phase_q + 4'd1;
              rel      = done && (phase_q == PH_S_REV);
            end else begin
              idle_en = 1'b1;
            end
          end else if (prog_q == PROG_BREAK) begin
            if (phase_q == PH_PREP) begin
              enter_en = item_i.priority_ready;
              enter_ph = PH_B_FJOLT;
            end else if (phase_q == PH_B_REL) begin
              idle_en = !item_i.priority_active;
              boff    = !item_i.priority_active;
            end else if (phase_q == PH_B_RDSTOP) begin
              enter_en = done;
              if (cycle_q < cfg_i.total_cycles) begin
                enter_ph = PH_B_FJOLT;
                if (done) cycle_d = cycle_q + 4'd1;
              end else begin
                enter_ph = PH_B_REL;
                rel      = done;
              end
            end else if (timed) begin
              enter_en = done;
              enter_ph = phase_q + 4'd1;
            end else begin
              idle_en = 1'b1;
            end
          end else begin
            // An unknown program code falls back to idle.
            idle_en = 1'b1;
          end
        end
      end
    endcase

    if (idle_en) begin
      prog_d   = PROG_NONE;
      phase_d  = PH_IDLE;
      ptimer_d = '0;
      eflag_d  = 1'b0;
      etimer_d = '0;
      cycle_d  = 4'd0;
    end else if (enter_en) begin
      phase_d  = enter_ph;
      ptimer_d = '0;
      etimer_d = '0;
      eflag_d  = (motor_of(prog_d, enter_ph) != MOTOR_STOP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q   <= PROG_NONE;
      phase_q  <= PH_IDLE;
      ptimer_q <= '0;
      eflag_q  <= 1'b0;
      etimer_q <= '0;
      cycle_q  <= 4'd0;
    end else if (step_en_i) begin
      prog_q   <= prog_d;
      phase_q  <= phase_d;
      ptimer_q <= ptimer_d;
      eflag_q  <= eflag_d;
      etimer_q <= etimer_d;
      cycle_q  <= cycle_d;
    end
  end

  always_comb begin
    res_o.motor_drive      = motor_of(prog_d, phase_d);
    res_o.request_priority = req;
    res_o.release_priority = rel;
    res_o.release_now      = relnow;
    res_o.behavior_off     = boff;
    res_o.program_res      = prog_d;
    res_o.phase_code       = phase_d;
    res_o.cycle_number     = (prog_d == PROG_BREAK) ? cycle_d : 4'd0;
    res_o.safety_trip      = trip;
  end

`ifndef SYNTHESIS
  a_prog_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q != 2'd3)
    else $error("program select holds an unused code");

  a_energized_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eflag_q |-> (motor_of(prog_q, phase_q) != MOTOR_STOP))
    else $error("energized flag set while the motor is stopped");

  a_cycle_only_breakaway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cycle_q != 4'd0) |-> (prog_q == PROG_BREAK))
    else $error("cycle count left over outside the breakaway test");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prog_q == PROG_NONE) |-> (phase_q == PH_IDLE && ptimer_q == '0 && !eflag_q))
    else $error("idle with phase state not cleared");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/motor_breakaway_test_sequencer.sv
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Each item is registered on entry, stepped through the phase logic and its
// result registered on exit, so an item can be taken every cycle unless the
// output stalls. Reset clears the sequence state and loads the default timings.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall_o in the same cycle.
module motor_breakaway_test_sequencer
  import mbts_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire in_item_t                in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_item_t                    out_data_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, res;
  logic      out_valid_q;
  logic      advance;
  cfg_t      cfg;

  // The held item moves on when the result register is empty or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  mbts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mbts_seq #(
    .TimerWidth (TIMER_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_relnow_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.release_now) |-> (out_data_o.program_res == PROG_NONE))
    else $error("immediate release reported with a program still running");

  a_start_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.request_priority) |->
      (out_data_o.behavior_off && out_data_o.phase_code == PH_PREP))
    else $error("priority request without entry to the preparing phase");

  a_trip_relnow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.safety_trip) |-> out_data_o.release_now)
    else $error("safety trip without immediate release");
`endif

endmodule

`default_nettype wire
